@@ hdl/cafu_pkg.sv @@
// Shared types, constants and helper functions of the complementary attitude filter unit.
// Used by the controller, the datapath and the top level.
package cafu_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 8;

  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W  = 24;
  localparam int WEIGHT_W = 17;
  localparam int CNT_W    = 5;
  localparam int XY_W     = 36;
  localparam int Z_W      = 28;
  localparam int ACC_W    = 56;
  localparam int GDT_W    = 33;
  localparam int OPA_W    = 18;
  localparam int OPB_W    = 34;
  localparam int MUL_W    = OPA_W + OPB_W;
  localparam int SQRT_W   = 32;
  localparam int REM_W    = SQRT_W + 3;

  localparam int SQRT_LAST  = SQRT_W - 1;
  localparam int STEP_LAST  = CORDIC_STEPS - 1;
  localparam int ACC16_SHIFT = 4;
  localparam int STORE_SHIFT = 20 - ANGLE_FRAC_BITS;
  localparam int YAW_SHIFT   = 20 - ANGLE_FRAC_BITS;
  localparam int BLEND_SHIFT = 36 - ANGLE_FRAC_BITS;
  localparam int FIRST_SHIFT = 16 - ANGLE_FRAC_BITS;

  localparam longint YAW_HALF   = longint'(1) << (YAW_SHIFT - 1);
  localparam longint BLEND_HALF = longint'(1) << (BLEND_SHIFT - 1);
  localparam longint FIRST_HALF = longint'(1) << (FIRST_SHIFT - 1);
  localparam longint HALF_TURN  = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint DEG16_180  = longint'(180) * 65536;
  localparam longint ANGLE_MAX  = (longint'(1) << (ANGLE_W - 1)) - 1;
  localparam longint ANGLE_MIN  = -(longint'(1) << (ANGLE_W - 1));
  localparam longint WEIGHT_ONE = 65536;
  localparam longint WEIGHT_RST = 64225;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AY2,
    MUL_AZ2,
    MUL_GDT,
    MUL_A_STORE,
    MUL_A_GDT,
    MUL_B_ACC
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_YAW
  } acc_op_e;

  typedef enum logic [1:0] {
    AXIS_ROLL,
    AXIS_PITCH,
    AXIS_YAW
  } axis_e;

  typedef struct packed {
    logic             load;
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             cordic_init;
    logic             cordic_step;
    logic             cordic_save;
    logic [CNT_W-1:0] step;
    axis_e            axis;
    logic             commit;
    logic             first_init;
    logic             publish;
  } cmd_t;

  typedef struct packed {
    logic started;
  } status_t;

  function automatic logic signed [Z_W-1:0] atan_deg16(input logic [CNT_W-1:0] idx);
    case (idx)
      5'd0:    return Z_W'(2949120);
      5'd1:    return Z_W'(1740967);
      5'd2:    return Z_W'(919879);
      5'd3:    return Z_W'(466945);
      5'd4:    return Z_W'(234379);
      5'd5:    return Z_W'(117304);
      5'd6:    return Z_W'(58666);
      5'd7:    return Z_W'(29335);
      5'd8:    return Z_W'(14668);
      5'd9:    return Z_W'(7334);
      5'd10:   return Z_W'(3667);
      5'd11:   return Z_W'(1833);
      5'd12:   return Z_W'(917);
      5'd13:   return Z_W'(458);
      5'd14:   return Z_W'(229);
      5'd15:   return Z_W'(115);
      5'd16:   return Z_W'(57);
      5'd17:   return Z_W'(29);
      5'd18:   return Z_W'(14);
      5'd19:   return Z_W'(7);
      5'd20:   return Z_W'(4);
      5'd21:   return Z_W'(2);
      5'd22:   return Z_W'(1);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(ANGLE_MAX)) begin
      return ANGLE_W'(ANGLE_MAX);
    end else if (v < ACC_W'(ANGLE_MIN)) begin
      return ANGLE_W'(ANGLE_MIN);
    end
    return v[ANGLE_W-1:0];
  endfunction

endpackage

@@ hdl/cafu_in_if.sv @@
// Input channel of the filter: one accelerometer and gyro sample set with its time step.
// Depends on nothing else.
interface cafu_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic        [15:0] time_step;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_step,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_step,
    output ready
  );
endinterface

@@ hdl/cafu_out_if.sv @@
// Output channel of the filter: roll, pitch and yaw angles with the first-sample flag.
// Depends on nothing else.
interface cafu_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] roll_angle;
  logic signed [23:0] pitch_angle;
  logic signed [23:0] yaw_angle;
  logic               first_sample;

  modport source (
    output valid, roll_angle, pitch_angle, yaw_angle, first_sample,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, pitch_angle, yaw_angle, first_sample,
    output ready
  );
endinterface

@@ hdl/cafu_ctrl.sv @@
// Sequencer of the filter: steps the square root, the CORDIC and the blend per sample.
// Depends on cafu_pkg for the command and status types.
module cafu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cafu_pkg::status_t status_i,
  output cafu_pkg::cmd_t    cmd_o
);
  import cafu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_A, S_SQ_B, S_SQ_C, S_SQRT_INIT, S_SQRT,
    S_COR_INIT, S_COR, S_COR_SAVE, S_FIRST,
    S_BL_GDT, S_BL_AS, S_BL_AG, S_BL_B, S_BL_ADD, S_BL_COMMIT,
    S_YAW_GDT, S_YAW_SUM, S_YAW_COMMIT, S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  axis_e            axis_q;
  logic             out_valid_q;
  logic             publish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign publish     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= AXIS_ROLL;
      out_valid_q <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SQ_A;
          end
        end
        S_SQ_A:      state_q <= S_SQ_B;
        S_SQ_B:      state_q <= S_SQ_C;
        S_SQ_C:      state_q <= S_SQRT_INIT;
        S_SQRT_INIT: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SQRT_LAST)) begin
            axis_q  <= AXIS_ROLL;
            state_q <= S_COR_INIT;
          end
        end
        S_COR_INIT: begin
          cnt_q   <= '0;
          state_q <= S_COR;
        end
        S_COR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(STEP_LAST)) begin
            state_q <= S_COR_SAVE;
          end
        end
        S_COR_SAVE: begin
          if (axis_q == AXIS_ROLL) begin
            axis_q  <= AXIS_PITCH;
            state_q <= S_COR_INIT;
          end else if (status_i.started) begin
            axis_q  <= AXIS_ROLL;
            state_q <= S_BL_GDT;
          end else begin
            state_q <= S_FIRST;
          end
        end
        S_FIRST:  state_q <= S_DONE;
        S_BL_GDT: state_q <= S_BL_AS;
        S_BL_AS:  state_q <= S_BL_AG;
        S_BL_AG:  state_q <= S_BL_B;
        S_BL_B:   state_q <= S_BL_ADD;
        S_BL_ADD: state_q <= S_BL_COMMIT;
        S_BL_COMMIT: begin
          if (axis_q == AXIS_ROLL) begin
            axis_q  <= AXIS_PITCH;
            state_q <= S_BL_GDT;
          end else begin
            axis_q  <= AXIS_YAW;
            state_q <= S_YAW_GDT;
          end
        end
        S_YAW_GDT:    state_q <= S_YAW_SUM;
        S_YAW_SUM:    state_q <= S_YAW_COMMIT;
        S_YAW_COMMIT: state_q <= S_DONE;
        S_DONE: begin
          if (publish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc_op  = ACC_HOLD;
    cmd_o.step    = cnt_q;
    cmd_o.axis    = axis_q;
    cmd_o.publish = publish;
    case (state_q)
      S_IDLE:       cmd_o.load = in_valid_i;
      S_SQ_A:       cmd_o.mul_sel = MUL_AY2;
      S_SQ_B: begin
        cmd_o.mul_sel = MUL_AZ2;
        cmd_o.acc_op  = ACC_LOAD;
      end
      S_SQ_C:       cmd_o.acc_op = ACC_ADD;
      S_SQRT_INIT:  cmd_o.sqrt_init = 1'b1;
      S_SQRT:       cmd_o.sqrt_step = 1'b1;
      S_COR_INIT:   cmd_o.cordic_init = 1'b1;
      S_COR:        cmd_o.cordic_step = 1'b1;
      S_COR_SAVE:   cmd_o.cordic_save = 1'b1;
      S_FIRST:      cmd_o.first_init = 1'b1;
      S_BL_GDT:     cmd_o.mul_sel = MUL_GDT;
      S_BL_AS:      cmd_o.mul_sel = MUL_A_STORE;
      S_BL_AG: begin
        cmd_o.mul_sel = MUL_A_GDT;
        cmd_o.acc_op  = ACC_LOAD;
      end
      S_BL_B: begin
        cmd_o.mul_sel = MUL_B_ACC;
        cmd_o.acc_op  = ACC_ADD;
      end
      S_BL_ADD:     cmd_o.acc_op = ACC_ADD;
      S_BL_COMMIT:  cmd_o.commit = 1'b1;
      S_YAW_GDT:    cmd_o.mul_sel = MUL_GDT;
      S_YAW_SUM:    cmd_o.acc_op = ACC_YAW;
      S_YAW_COMMIT: cmd_o.commit = 1'b1;
      default:      cmd_o.load = 1'b0;
    endcase
  end

endmodule

@@ hdl/cafu_datapath.sv @@
// Datapath of the filter: sample registers, square root, shared CORDIC, one multiplier,
// accumulator, angle state and result registers. Depends on cafu_pkg.
module cafu_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cafu_pkg::cmd_t                       cmd_i,
  output cafu_pkg::status_t                    status_o,
  input  logic                                 weight_we_i,
  input  logic        [cafu_pkg::WEIGHT_W-1:0] weight_i,
  input  logic signed [cafu_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [cafu_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [cafu_pkg::SAMPLE_W-1:0] accel_z_i,
  input  logic signed [cafu_pkg::SAMPLE_W-1:0] gyro_x_i,
  input  logic signed [cafu_pkg::SAMPLE_W-1:0] gyro_y_i,
  input  logic signed [cafu_pkg::SAMPLE_W-1:0] gyro_z_i,
  input  logic        [cafu_pkg::SAMPLE_W-1:0] time_step_i,
  output logic signed [cafu_pkg::ANGLE_W-1:0]  roll_o,
  output logic signed [cafu_pkg::ANGLE_W-1:0]  pitch_o,
  output logic signed [cafu_pkg::ANGLE_W-1:0]  yaw_o,
  output logic                                 first_o
);
  import cafu_pkg::*;

  logic        [WEIGHT_W-1:0] weight_q;
  logic                       started_q;
  logic                       first_q;
  logic signed [SAMPLE_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic        [SAMPLE_W-1:0] dt_q;
  logic signed [ACC_W-1:0]    prod_q, acc_q;
  logic signed [GDT_W-1:0]    gdt_q;
  logic        [SQRT_W-1:0]   n_q, root_q;
  logic        [REM_W-1:0]    rem_q;
  logic signed [XY_W-1:0]     x_q, y_q;
  logic signed [Z_W-1:0]      z_q, roll16_q, pitch16_q;
  logic                       zero_q;
  logic signed [ANGLE_W-1:0]  roll_q, pitch_q, yaw_q;
  logic signed [ANGLE_W-1:0]  out_roll_q, out_pitch_q, out_yaw_q;
  logic                       out_first_q;

  logic        [WEIGHT_W-1:0] a_w, b_w;
  logic signed [SAMPLE_W-1:0] g_sel;
  logic signed [ANGLE_W-1:0]  store_sel;
  logic signed [Z_W-1:0]      ang_sel;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic signed [MUL_W-1:0]    mul_p;
  logic signed [ACC_W-1:0]    prod_d;
  logic        [REM_W-1:0]    rem_t, trial;
  logic signed [XY_W-1:0]     x0, y0, dx, dy;
  logic signed [ACC_W-1:0]    blend_rnd, yaw_rnd, yaw_wrap, roll_first, pitch_first;

  assign status_o.started = started_q;
  assign roll_o  = out_roll_q;
  assign pitch_o = out_pitch_q;
  assign yaw_o   = out_yaw_q;
  assign first_o = out_first_q;

  assign a_w = (weight_q > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight_q;
  assign b_w = WEIGHT_W'(WEIGHT_ONE) - a_w;

  always_comb begin
    case (cmd_i.axis)
      AXIS_ROLL: begin
        g_sel     = gx_q;
        store_sel = roll_q;
        ang_sel   = roll16_q;
      end
      AXIS_PITCH: begin
        g_sel     = gy_q;
        store_sel = pitch_q;
        ang_sel   = pitch16_q;
      end
      default: begin
        g_sel     = gz_q;
        store_sel = yaw_q;
        ang_sel   = roll16_q;
      end
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      MUL_AY2: begin
        op_a = OPA_W'(ay_q);
        op_b = OPB_W'(ay_q);
      end
      MUL_AZ2: begin
        op_a = OPA_W'(az_q);
        op_b = OPB_W'(az_q);
      end
      MUL_GDT: begin
        op_a = OPA_W'(g_sel);
        op_b = OPB_W'($signed({1'b0, dt_q}));
      end
      MUL_A_STORE: begin
        op_a = OPA_W'($signed({1'b0, a_w}));
        op_b = OPB_W'(store_sel);
      end
      MUL_A_GDT: begin
        op_a = OPA_W'($signed({1'b0, a_w}));
        op_b = OPB_W'(gdt_q);
      end
      MUL_B_ACC: begin
        op_a = OPA_W'($signed({1'b0, b_w}));
        op_b = OPB_W'(ang_sel);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_p = op_a * op_b;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_A_STORE: prod_d = ACC_W'(mul_p) <<< STORE_SHIFT;
      MUL_B_ACC:   prod_d = ACC_W'(mul_p) <<< ACC16_SHIFT;
      default:     prod_d = ACC_W'(mul_p);
    endcase
  end

  assign rem_t = {rem_q[REM_W-3:0], n_q[SQRT_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_comb begin
    if (cmd_i.axis == AXIS_ROLL) begin
      y0 = XY_W'(ay_q) <<< 16;
      x0 = XY_W'(az_q) <<< 16;
    end else begin
      y0 = -(XY_W'(ax_q) <<< 16);
      x0 = XY_W'($signed({1'b0, root_q}));
    end
  end

  assign dx = y_q >>> cmd_i.step;
  assign dy = x_q >>> cmd_i.step;

  assign blend_rnd   = (acc_q + ACC_W'(BLEND_HALF)) >>> BLEND_SHIFT;
  assign yaw_rnd     = (acc_q + ACC_W'(YAW_HALF)) >>> YAW_SHIFT;
  assign roll_first  = (ACC_W'(roll16_q) + ACC_W'(FIRST_HALF)) >>> FIRST_SHIFT;
  assign pitch_first = (ACC_W'(pitch16_q) + ACC_W'(FIRST_HALF)) >>> FIRST_SHIFT;

  always_comb begin
    if (yaw_rnd > ACC_W'(HALF_TURN)) begin
      yaw_wrap = yaw_rnd - ACC_W'(2 * HALF_TURN);
    end else if (yaw_rnd < -ACC_W'(HALF_TURN)) begin
      yaw_wrap = yaw_rnd + ACC_W'(2 * HALF_TURN);
    end else begin
      yaw_wrap = yaw_rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= WEIGHT_W'(WEIGHT_RST);
      started_q   <= 1'b0;
      first_q     <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
    end else begin
      if (weight_we_i) begin
        weight_q <= weight_i;
      end
      if (cmd_i.first_init) begin
        roll_q    <= sat_angle(roll_first);
        pitch_q   <= sat_angle(pitch_first);
        yaw_q     <= '0;
        started_q <= 1'b1;
        first_q   <= 1'b1;
      end
      if (cmd_i.commit) begin
        case (cmd_i.axis)
          AXIS_ROLL: begin
            roll_q  <= sat_angle(blend_rnd);
            first_q <= 1'b0;
          end
          AXIS_PITCH: pitch_q <= sat_angle(blend_rnd);
          default:    yaw_q   <= sat_angle(yaw_wrap);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= gyro_x_i;
      gy_q <= gyro_y_i;
      gz_q <= gyro_z_i;
      dt_q <= time_step_i;
    end
    if (cmd_i.mul_sel == MUL_GDT) begin
      gdt_q <= GDT_W'(mul_p);
    end else begin
      prod_q <= prod_d;
    end
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= prod_q;
      ACC_ADD:  acc_q <= acc_q + prod_q;
      ACC_YAW:  acc_q <= ACC_W'(gdt_q) + (ACC_W'(yaw_q) <<< STORE_SHIFT);
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.sqrt_init) begin
      n_q    <= acc_q[SQRT_W-1:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      n_q <= {n_q[SQRT_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[SQRT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[SQRT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.cordic_init) begin
      zero_q <= (x0 == '0) && (y0 == '0);
      if (x0 < 0) begin
        z_q <= (y0 >= 0) ? Z_W'(DEG16_180) : -Z_W'(DEG16_180);
        x_q <= -x0;
        y_q <= -y0;
      end else begin
        z_q <= '0;
        x_q <= x0;
        y_q <= y0;
      end
    end else if (cmd_i.cordic_step) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_deg16(cmd_i.step);
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_deg16(cmd_i.step);
      end
    end
    if (cmd_i.cordic_save) begin
      if (cmd_i.axis == AXIS_ROLL) begin
        roll16_q <= zero_q ? '0 : z_q;
      end else begin
        pitch16_q <= zero_q ? '0 : z_q;
      end
    end
    if (cmd_i.publish) begin
      out_roll_q  <= roll_q;
      out_pitch_q <= pitch_q;
      out_yaw_q   <= yaw_q;
      out_first_q <= first_q;
    end
  end

endmodule

@@ hdl/complementary_attitude_filter_unit.sv @@
// Complementary attitude filter unit: one sample in, one roll/pitch/yaw result out.
// From the input transfer to the result it runs a 32-step square root, two 16-step passes of one
// shared CORDIC, a blend per axis and the yaw update; the first sample skips both and only initializes.
// One sample at a time; a new sample is taken while a result waits.
// Reset clears the angles and the started flag and loads the blend weight with 64225.
// Depends on cafu_pkg, cafu_in_if, cafu_out_if, cafu_ctrl and cafu_datapath.
module complementary_attitude_filter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  cafu_in_if.sink                              sample_i,
  cafu_out_if.source                           attitude_o,
  input  logic                                 blend_weight_we_i,
  input  logic        [cafu_pkg::WEIGHT_W-1:0] blend_weight_i
);
  import cafu_pkg::*;

  cmd_t    cmd;
  status_t status;

  cafu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (attitude_o.valid),
    .out_ready_i (attitude_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cafu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .weight_we_i (blend_weight_we_i),
    .weight_i    (blend_weight_i),
    .accel_x_i   (sample_i.accel_x),
    .accel_y_i   (sample_i.accel_y),
    .accel_z_i   (sample_i.accel_z),
    .gyro_x_i    (sample_i.gyro_x),
    .gyro_y_i    (sample_i.gyro_y),
    .gyro_z_i    (sample_i.gyro_z),
    .time_step_i (sample_i.time_step),
    .roll_o      (attitude_o.roll_angle),
    .pitch_o     (attitude_o.pitch_angle),
    .yaw_o       (attitude_o.yaw_angle),
    .first_o     (attitude_o.first_sample)
  );

`ifndef SYNTHESIS
  // A sample transfer always starts a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> !sample_i.ready)
    else $error("input taken again right after a transfer");

  // The first sample only initializes, so its yaw is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    attitude_o.valid && attitude_o.first_sample |-> attitude_o.yaw_angle == '0)
    else $error("first sample result with nonzero yaw");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(attitude_o.valid) |-> $past(!sample_i.ready))
    else $error("result published while idle");
`endif

endmodule

@@ tb/sv/tb_cafu_pkg.sv @@
// Testbench types for the complementary attitude filter unit.
// Depends on nothing; used by the testbench top only.
package tb_cafu_pkg;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic        [15:0] dt;
  } imu_sample_t;

  typedef struct {
    logic signed [23:0] roll;
    logic signed [23:0] pitch;
    logic signed [23:0] yaw;
    logic               first;
  } attitude_t;

endpackage

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of complementary_attitude_filter_unit: random and directed IMU
// samples, a fixed-point attitude predictor, and checks of every result transfer.
// Depends on cafu_pkg, tb_cafu_pkg, cafu_in_if, cafu_out_if and the unit itself.
module tb_top;
  import tb_cafu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic blend_weight_we_i = 1'b0;
  logic [cafu_pkg::WEIGHT_W-1:0] blend_weight_i = '0;

  cafu_in_if  sample_ch ();
  cafu_out_if attitude_ch ();

  complementary_attitude_filter_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_i          (sample_ch.sink),
    .attitude_o        (attitude_ch.source),
    .blend_weight_we_i (blend_weight_we_i),
    .blend_weight_i    (blend_weight_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  imu_sample_t pending_samples[$];
  attitude_t   expected_attitudes[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_hold = 0;
  int          quiet_cycles = 0;
  logic        driving = 1'b0;

  longint      roll_q, pitch_q, yaw_q;
  logic        filter_started;
  logic [16:0] alpha_q;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return tbl[i];
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(180) * 65536 : -longint'(180) * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < cafu_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic attitude_t predict_attitude(imu_sample_t s);
    attitude_t r;
    longint ax, ay, az, roll16, pitch16, a, b, gr, gp, yf, yw;
    ax = s.ax; ay = s.ay; az = s.az;
    roll16 = vector_angle(ay * 65536, az * 65536);
    pitch16 = vector_angle(-ax * 65536, int_sqrt(longint'(ay * ay + az * az) << 32));
    r.first = !filter_started;
    if (!filter_started) begin
      roll_q = clamp24(round_half_up(roll16, 8));
      pitch_q = clamp24(round_half_up(pitch16, 8));
      yaw_q = 0;
      filter_started = 1'b1;
    end else begin
      a = (alpha_q > 65536) ? 65536 : longint'(alpha_q);
      b = 65536 - a;
      gr = roll_q * 4096 + longint'(s.gx) * longint'(s.dt);
      gp = pitch_q * 4096 + longint'(s.gy) * longint'(s.dt);
      yf = yaw_q * 4096 + longint'(s.gz) * longint'(s.dt);
      roll_q = clamp24(round_half_up(a * gr + b * roll16 * 16, 28));
      pitch_q = clamp24(round_half_up(a * gp + b * pitch16 * 16, 28));
      yw = round_half_up(yf, 12);
      if (yw > 46080) yw -= 92160;
      else if (yw < -46080) yw += 92160;
      yaw_q = clamp24(yw);
    end
    r.roll = roll_q[23:0];
    r.pitch = pitch_q[23:0];
    r.yaw = yaw_q[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.accel_x = '0; sample_ch.accel_y = '0; sample_ch.accel_z = '0;
    sample_ch.gyro_x = '0; sample_ch.gyro_y = '0; sample_ch.gyro_z = '0;
    sample_ch.time_step = '0;
    attitude_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (sample_ch.valid && sample_ch.ready) begin
      expected_attitudes.push_back(predict_attitude('{sample_ch.accel_x, sample_ch.accel_y,
        sample_ch.accel_z, sample_ch.gyro_x, sample_ch.gyro_y, sample_ch.gyro_z,
        sample_ch.time_step}));
    end
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (driving && pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        imu_sample_t s;
        s = pending_samples.pop_front();
        sample_ch.valid <= 1'b1;
        sample_ch.accel_x <= s.ax; sample_ch.accel_y <= s.ay; sample_ch.accel_z <= s.az;
        sample_ch.gyro_x <= s.gx; sample_ch.gyro_y <= s.gy; sample_ch.gyro_z <= s.gz;
        sample_ch.time_step <= s.dt;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (attitude_ch.valid && attitude_ch.ready) begin
      if (expected_attitudes.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        attitude_t e;
        e = expected_attitudes.pop_front();
        if (attitude_ch.roll_angle !== e.roll)
          report_mismatch("roll", attitude_ch.roll_angle, e.roll);
        if (attitude_ch.pitch_angle !== e.pitch)
          report_mismatch("pitch", attitude_ch.pitch_angle, e.pitch);
        if (attitude_ch.yaw_angle !== e.yaw)
          report_mismatch("yaw", attitude_ch.yaw_angle, e.yaw);
        if (attitude_ch.first_sample !== e.first)
          report_mismatch("first_sample", attitude_ch.first_sample, e.first);
      end
    end
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      attitude_ch.ready <= 1'b0;
    end else begin
      attitude_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (attitude_ch.valid && attitude_ch.ready)
        || !driving)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    s.ax = pick_value(); s.ay = pick_value(); s.az = pick_value();
    s.gx = pick_value(); s.gy = pick_value(); s.gz = pick_value();
    s.dt = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1000));
    return s;
  endfunction

  task automatic run_phase(int count, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) pending_samples.push_back(random_sample());
    driving = 1'b1;
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || sample_ch.valid || expected_attitudes.size() != 0);
    driving = 1'b0;
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_weight(logic [16:0] w);
    @(posedge clk_i);
    blend_weight_we_i <= 1'b1;
    blend_weight_i <= w;
    @(posedge clk_i);
    blend_weight_we_i <= 1'b0;
    alpha_q = w;
  endtask

  initial begin
    filter_started = 1'b0;
    alpha_q = 17'd64225;
    roll_q = 0; pitch_q = 0; yaw_q = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
    pending_samples.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                                16'sh7fff, 16'hffff});
    pending_samples.push_back('{16'sh8000, 16'sh7fff, -16'sd1, 16'sh8000, 16'sh7fff,
                                16'sh7fff, 16'hffff});
    pending_samples.push_back('{16'sd100, -16'sd5, -16'sd300, 16'sd0, 16'sd0, 16'sh7fff,
                                16'hffff});
    pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000,
                                16'hffff});
    pending_samples.push_back('{-16'sd1, 16'sd0, 16'sd200, 16'sd0, 16'sd0, 16'sh8000,
                                16'hffff});
    run_phase(0, 32, 58);
    write_weight(17'd65536);
    pending_samples.push_back('{16'sd0, 16'sd0, 16'sd100, 16'sh7fff, 16'sh7fff, 16'sd0,
                                16'hffff});
    pending_samples.push_back('{16'sd0, 16'sd0, 16'sd100, 16'sh7fff, 16'sh7fff, 16'sd0,
                                16'hffff});
    run_phase(0, 32, 58);
    write_weight(17'h1ffff);
    run_phase(20, 32, 58);
    write_weight(17'd0);
    run_phase(150, 32, 58);
    write_weight(17'd64225);
    recv_hold = 2000;
    run_phase(350, 32, 58);
    write_weight(17'($urandom_range(65536)));
    run_phase(350, 58, 32);
    write_weight(17'($urandom));
    run_phase(350, 0, 0);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ complementary_attitude_filter_unit.f @@
hdl/cafu_pkg.sv
hdl/cafu_in_if.sv
hdl/cafu_out_if.sv
hdl/cafu_ctrl.sv
hdl/cafu_datapath.sv
hdl/complementary_attitude_filter_unit.sv
tb/sv/tb_cafu_pkg.sv
tb/sv/tb_top.sv
